/* design/cptm_pkg.sv */
package cptm_pkg;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam int          BUF_BYTES = 8;
  localparam logic [31:0] MS_TO_US  = 32'd1000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_NEW,
    ST_FLUSH
  } state_t;

  // latched input item
  typedef struct packed {
    logic        func;
    logic        channel;
    logic [10:0] frame_id;
    logic [3:0]  start_index;
    logic [3:0]  byte_count;
    logic [63:0] data_bytes;
    logic [15:0] period_ms;
    logic [31:0] now_us;
  } cmd_t;

  // one port table entry as held in the ram
  typedef struct packed {
    logic [10:0] ident;
    logic [15:0] interval;
    logic [31:0] sent_time;
    logic [63:0] buffer;
  } entry_t;

endpackage

/* design/cptm_ram.sv */
module cptm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/cptm_entry_upd.sv */
module cptm_entry_upd (
  input  cptm_pkg::cmd_t   cmd,
  input  cptm_pkg::entry_t cur,
  input  logic             fresh,
  output cptm_pkg::entry_t merged,
  output cptm_pkg::entry_t stamped,
  output logic             due
);

  logic [63:0] base;
  logic [31:0] elapsed;
  logic [31:0] need;

  // byte merge: buffer position p takes write byte p - start_index
  always_comb begin
    logic [3:0] pos;
    logic [3:0] j;
    base = fresh ? 64'd0 : cur.buffer;
    merged.ident = cmd.frame_id;
    merged.sent_time = fresh ? 32'd0 : cur.sent_time;
    if (fresh || (cmd.period_ms < cur.interval)) begin
      merged.interval = cmd.period_ms;
    end else begin
      merged.interval = cur.interval;
    end
    merged.buffer = base;
    for (int p = 0; p < cptm_pkg::BUF_BYTES; p++) begin
      pos = 4'(p);
      j = pos - cmd.start_index;
      if ((pos >= cmd.start_index) && (j < cmd.byte_count)) begin
        merged.buffer[8*p +: 8] = cmd.data_bytes[8*j[2:0] +: 8];
      end
    end
  end

  // wrapped elapsed time against period in microseconds
  assign elapsed = cmd.now_us - cur.sent_time;
  assign need    = 32'(cur.interval) * cptm_pkg::MS_TO_US;
  assign due     = (elapsed >= need);

  always_comb begin
    stamped = cur;
    stamped.sent_time = cmd.now_us;
  end

endmodule

/* design/can_periodic_tx_mailbox.sv */
// Periodic CAN transmit mailbox for one bus. Ports live in a single-port-read
// ram, one entry per port in creation order, and a sequencer visits one entry
// per cycle while the scan is not stalled. A write item scans ports until its id
// matches and merges into that entry, or creates a new port after the last one
// unless the table is full. A tick item scans every port, sends the due ones and
// then releases the final frame with last set; the scan ends early once
// WAIT_SLOTS frames are chosen. A frame that must leave while the output
// register is still held stalls the scan. Writes for the other bus are taken
// and dropped. The registered ram read of the next index sets that rate.
module can_periodic_tx_mailbox #(
  parameter int MAX_PORTS  = 8,
  parameter int WAIT_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic        channel,
  input  logic [10:0] frame_id,
  input  logic [3:0]  start_index,
  input  logic [3:0]  byte_count,
  input  logic [63:0] data_bytes,
  input  logic [15:0] period_ms,
  input  logic [31:0] now_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] tx_frame_id,
  output logic [63:0] tx_payload,
  output logic        last
);

  localparam int AW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
  localparam int CW = $clog2(MAX_PORTS + 1);
  localparam int NW = $clog2(WAIT_SLOTS + 1);
  localparam int EW = $bits(cptm_pkg::entry_t);

  cptm_pkg::state_t state, state_next;
  cptm_pkg::cmd_t   cmd, cmd_next;
  logic [AW-1:0]    idx, idx_next;
  logic [CW-1:0]    ports_in_use, ports_in_use_next;
  logic [NW-1:0]    sent_cnt, sent_cnt_next;
  logic             own_channel;
  logic             pend_valid, pend_valid_next;
  logic             pend_load;
  logic [10:0]      pend_id;
  logic [63:0]      pend_payload;

  logic             push, push_last;
  logic             out_free;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [EW-1:0]    ram_wdata;
  cptm_pkg::entry_t rd_entry, merged, stamped;
  logic             due;
  logic             last_port;
  logic             full;
  logic [CW-1:0]    idx_inc;

  cptm_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_PORTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_next),
    .rdata(rd_entry)
  );

  cptm_entry_upd u_upd (
    .cmd    (cmd),
    .cur    (rd_entry),
    .fresh  (state == cptm_pkg::ST_NEW),
    .merged (merged),
    .stamped(stamped),
    .due    (due)
  );

  assign out_free  = !out_valid || out_ready;
  assign idx_inc   = CW'(idx) + CW'(1);
  assign last_port = (idx_inc >= ports_in_use);
  assign full      = (ports_in_use == CW'(MAX_PORTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cptm_pkg::ST_IDLE;
      ports_in_use <= '0;
      pend_valid   <= 1'b0;
      own_channel  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      ports_in_use <= ports_in_use_next;
      pend_valid   <= pend_valid_next;
      if (cfg_we) begin
        own_channel <= cfg_data;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    idx      <= idx_next;
    sent_cnt <= sent_cnt_next;
    if (pend_load) begin
      pend_id      <= rd_entry.ident;
      pend_payload <= rd_entry.buffer;
    end
    if (push) begin
      tx_frame_id <= pend_id;
      tx_payload  <= pend_payload;
      last        <= push_last;
    end
  end

  always_comb begin
    state_next        = state;
    cmd_next          = cmd;
    idx_next          = idx;
    ports_in_use_next = ports_in_use;
    sent_cnt_next     = sent_cnt;
    pend_valid_next   = pend_valid;
    pend_load         = 1'b0;
    push              = 1'b0;
    push_last         = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = idx;
    ram_wdata         = merged;
    in_ready          = 1'b0;

    unique case (state)
      cptm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_next      = '{func, channel, frame_id, start_index, byte_count,
                            data_bytes, period_ms, now_us};
          idx_next      = '0;
          sent_cnt_next = '0;
          if (func == cptm_pkg::FUNC_TICK) begin
            state_next = (ports_in_use == '0) ? cptm_pkg::ST_FLUSH : cptm_pkg::ST_CMP;
          end else if (channel == own_channel) begin
            state_next = (ports_in_use == '0) ? cptm_pkg::ST_NEW : cptm_pkg::ST_CMP;
          end
        end
      end

      cptm_pkg::ST_CMP: begin
        if (cmd.func == cptm_pkg::FUNC_WRITE) begin
          if (rd_entry.ident == cmd.frame_id) begin
            ram_we     = 1'b1;
            state_next = cptm_pkg::ST_IDLE;
          end else if (last_port) begin
            state_next = full ? cptm_pkg::ST_IDLE : cptm_pkg::ST_NEW;
          end else begin
            idx_next = idx + AW'(1);
          end
        end else if (due && (sent_cnt < NW'(WAIT_SLOTS))) begin
          // previous chosen frame leaves now, this one is held back to learn last
          if (!pend_valid || out_free) begin
            ram_we          = 1'b1;
            ram_wdata       = stamped;
            push            = pend_valid;
            pend_load       = 1'b1;
            pend_valid_next = 1'b1;
            sent_cnt_next   = sent_cnt + NW'(1);
            if (last_port || (sent_cnt_next == NW'(WAIT_SLOTS))) begin
              state_next = cptm_pkg::ST_FLUSH;
            end else begin
              idx_next = idx + AW'(1);
            end
          end
        end else if (last_port) begin
          state_next = cptm_pkg::ST_FLUSH;
        end else begin
          idx_next = idx + AW'(1);
        end
      end

      cptm_pkg::ST_NEW: begin
        ram_we            = 1'b1;
        ram_waddr         = AW'(ports_in_use);
        ports_in_use_next = ports_in_use + CW'(1);
        state_next        = cptm_pkg::ST_IDLE;
      end

      cptm_pkg::ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = cptm_pkg::ST_IDLE;
        end else if (out_free) begin
          push            = 1'b1;
          push_last       = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = cptm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = cptm_pkg::ST_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ports_in_use <= CW'(MAX_PORTS))
    else $error("port count beyond table size");

  a_slots_bound: assert property (@(posedge clk) disable iff (rst)
    sent_cnt <= NW'(WAIT_SLOTS) || state == cptm_pkg::ST_IDLE)
    else $error("more frames chosen than wait slots");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == cptm_pkg::ST_IDLE |-> !pend_valid)
    else $error("held frame left behind at end of tick");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == cptm_pkg::ST_CMP || state == cptm_pkg::ST_NEW))
    else $error("table write outside scan or create");

  a_new_grows: assert property (@(posedge clk) disable iff (rst)
    state == cptm_pkg::ST_NEW |=> ports_in_use == $past(ports_in_use) + CW'(1))
    else $error("port creation did not grow the table");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

typedef struct packed {
  logic [10:0] ident;
  logic [63:0] payload;
  logic        last;
} tx_frame_t;

class frame_scoreboard #(int PORTS = 8, int SLOTS = 4);
  bit        own_ch;
  bit [10:0] ident[PORTS];
  bit [15:0] interval[PORTS];
  bit [31:0] sent_at[PORTS];
  bit [63:0] buffer[PORTS];
  int        ports_open;
  tx_frame_t frames_due[$];
  int        errors;
  int        frames_checked;
  int        writes_seen;
  int        ticks_seen;

  // update the port table for one accepted item and queue the frames it sends
  function void accept_item(cptm_pkg::cmd_t c);
    int        slot;
    int        i;
    int        pos;
    int        n;
    int        hits[SLOTS];
    bit [31:0] elapsed;
    bit [31:0] need;
    tx_frame_t f;
    if (c.func == cptm_pkg::FUNC_WRITE) begin
      writes_seen++;
      if (c.channel != own_ch) return;
      slot = -1;
      for (i = 0; i < ports_open; i++) begin
        if (ident[i] == c.frame_id) begin
          slot = i;
          break;
        end
      end
      if (slot < 0) begin
        // table full, new id dropped
        if (ports_open >= PORTS) return;
        slot = ports_open;
        ports_open++;
        ident[slot] = c.frame_id;
        interval[slot] = c.period_ms;
        sent_at[slot] = '0;
        buffer[slot] = '0;
      end
      for (i = 0; i < c.byte_count; i++) begin
        pos = c.start_index + i;
        if (pos >= cptm_pkg::BUF_BYTES) break;
        buffer[slot][8*pos +: 8] = c.data_bytes[8*i +: 8];
      end
      if (c.period_ms < interval[slot]) interval[slot] = c.period_ms;
    end else begin
      ticks_seen++;
      n = 0;
      for (i = 0; i < ports_open; i++) begin
        elapsed = c.now_us - sent_at[i];
        need = {16'd0, interval[i]} * cptm_pkg::MS_TO_US;
        if (elapsed >= need && n < SLOTS) begin
          hits[n] = i;
          n++;
        end
      end
      for (i = 0; i < n; i++) begin
        f.ident = ident[hits[i]];
        f.payload = buffer[hits[i]];
        f.last = (i == n - 1);
        frames_due.push_back(f);
        sent_at[hits[i]] = c.now_us;
      end
    end
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 30) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task check_frame(logic [10:0] id, logic [63:0] payload, logic last_flag);
    tx_frame_t want;
    frames_checked++;
    if (frames_due.size() == 0) begin
      report($sformatf("frame id %h arrived with none pending", id));
      return;
    end
    want = frames_due.pop_front();
    if (id !== want.ident)
      report($sformatf("tx_frame_id %h, expected %h", id, want.ident));
    if (payload !== want.payload)
      report($sformatf("id %h tx_payload %h, expected %h", want.ident, payload, want.payload));
    if (last_flag !== want.last)
      report($sformatf("id %h last %b, expected %b", want.ident, last_flag, want.last));
  endtask
endclass

module tb;

  localparam int MAX_PORTS     = 8;
  localparam int WAIT_SLOTS    = 4;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 78;

  logic        clk;
  logic        rst         = 1'b1;
  logic        cfg_we      = 1'b0;
  logic        cfg_data    = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic        func        = cptm_pkg::FUNC_WRITE;
  logic        channel     = 1'b0;
  logic [10:0] frame_id    = '0;
  logic [3:0]  start_index = '0;
  logic [3:0]  byte_count  = '0;
  logic [63:0] data_bytes  = '0;
  logic [15:0] period_ms   = '0;
  logic [31:0] now_us      = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [10:0] tx_frame_id;
  logic [63:0] tx_payload;
  logic        last;

  frame_scoreboard #(MAX_PORTS, WAIT_SLOTS) sb = new;

  bit tx_calm;
  bit rx_calm;
  int rx_hold;
  int quiet_cycles;
  int cfg_writes;

  can_periodic_tx_mailbox #(
    .MAX_PORTS  (MAX_PORTS),
    .WAIT_SLOTS (WAIT_SLOTS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .channel     (channel),
    .frame_id    (frame_id),
    .start_index (start_index),
    .byte_count  (byte_count),
    .data_bytes  (data_bytes),
    .period_ms   (period_ms),
    .now_us      (now_us),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tx_frame_id (tx_frame_id),
    .tx_payload  (tx_payload),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pause_len(bit calm);
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 7);
  endfunction

  function automatic cptm_pkg::cmd_t write_item(bit ch, bit [10:0] id, bit [3:0] start,
                                                bit [3:0] count, bit [63:0] data,
                                                bit [15:0] period);
    cptm_pkg::cmd_t c;
    c.func = cptm_pkg::FUNC_WRITE;
    c.channel = ch;
    c.frame_id = id;
    c.start_index = start;
    c.byte_count = count;
    c.data_bytes = data;
    c.period_ms = period;
    c.now_us = $urandom();
    return c;
  endfunction

  function automatic cptm_pkg::cmd_t tick_item(bit [31:0] stamp);
    cptm_pkg::cmd_t c;
    c.func = cptm_pkg::FUNC_TICK;
    c.channel = 1'($urandom_range(0, 1));
    c.frame_id = 11'($urandom_range(0, 2047));
    c.start_index = 4'($urandom_range(0, 15));
    c.byte_count = 4'($urandom_range(0, 8));
    c.data_bytes = {$urandom(), $urandom()};
    c.period_ms = 16'($urandom());
    c.now_us = stamp;
    return c;
  endfunction

  function automatic bit [3:0] pick_start();
    if ($urandom_range(0, 3) == 0) return 4'($urandom_range(8, 15));
    return 4'($urandom_range(0, 7));
  endfunction

  // periods only ever shrink, so keep zero rare
  function automatic bit [15:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 16'd0;
    if (r < 25) return 16'($urandom_range(1, 40));
    if (r < 45) return 16'($urandom());
    return 16'hFFFF;
  endfunction

  task automatic send(cptm_pkg::cmd_t c);
    int gap;
    gap = pause_len(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= c.func;
    channel <= c.channel;
    frame_id <= c.frame_id;
    start_index <= c.start_index;
    byte_count <= c.byte_count;
    data_bytes <= c.data_bytes;
    period_ms <= c.period_ms;
    now_us <= c.now_us;
    do @(posedge clk); while (!in_ready);
    sb.accept_item(c);
  endtask

  // hold input until every queued frame is out and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_channel(bit v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.own_ch = v;
    cfg_writes++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_frame(tx_frame_id, tx_payload, last);
        rx_hold = pause_len(rx_calm);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_ready <= (rx_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int        k;
    int        roll;
    int        phase;
    bit [10:0] pool[MAX_PORTS];
    bit [31:0] clock_us;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    set_channel(1'b0);

    // empty table, then other bus, creation, zero period, past-end bytes
    send(tick_item(32'd0));
    send(write_item(1'b1, 11'h005, 4'd0, 4'd8, {$urandom(), $urandom()}, 16'd10));
    send(write_item(1'b0, 11'h000, 4'd0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0));
    send(write_item(1'b0, 11'h7FF, 4'd6, 4'd8, 64'h0123_4567_89AB_CDEF, 16'hFFFF));
    send(write_item(1'b0, 11'h123, 4'd15, 4'd0, {$urandom(), $urandom()}, 16'd1));
    send(write_item(1'b0, 11'h123, 4'd3, 4'd2, {$urandom(), $urandom()}, 16'd2));
    send(tick_item(32'd0));
    send(tick_item(32'd1000));
    send(write_item(1'b0, 11'h2AA, 4'd0, 4'd4, {$urandom(), $urandom()}, 16'd5));
    send(write_item(1'b0, 11'h555, 4'd2, 4'd8, {$urandom(), $urandom()}, 16'd12));
    send(write_item(1'b0, 11'h0F0, 4'd0, 4'd8, 64'd0, 16'd30));
    send(write_item(1'b0, 11'h70E, 4'd7, 4'd8, {$urandom(), $urandom()}, 16'd3));
    send(write_item(1'b0, 11'h001, 4'd1, 4'd7, {$urandom(), $urandom()}, 16'd100));
    // table is full now
    send(write_item(1'b0, 11'h3C3, 4'd0, 4'd8, {$urandom(), $urandom()}, 16'd0));
    send(write_item(1'b0, 11'h7FF, 4'd0, 4'd8, {$urandom(), $urandom()}, 16'hFFFF));
    // every port due, more than the slots allow
    send(tick_item(32'hFFFF_FFFF));
    send(tick_item(32'h0000_0005));
    send(tick_item(32'h8000_0000));
    send(write_item(1'b1, 11'h000, 4'd0, 4'd8, {$urandom(), $urandom()}, 16'd0));
    send(tick_item(32'h8000_0000));

    pool = '{11'h000, 11'h7FF, 11'h123, 11'h2AA, 11'h555, 11'h0F0, 11'h70E, 11'h001};
    clock_us = 32'hFFF0_0000;
    for (phase = 0; phase < 4; phase++) begin
      drain();
      set_channel(phase % 2 == 0);
      tx_calm = (phase == 2);
      rx_calm = (phase == 1);
      for (k = 0; k < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          if ($urandom_range(0, 15) == 0) clock_us = $urandom();
          else clock_us += $urandom_range(0, 30000);
          send(tick_item(clock_us));
        end else if (roll < 82) begin
          send(write_item(sb.own_ch, pool[$urandom_range(0, MAX_PORTS - 1)], pick_start(),
                          4'($urandom_range(0, 8)), {$urandom(), $urandom()}, pick_period()));
        end else if (roll < 92) begin
          send(write_item(!sb.own_ch, pool[$urandom_range(0, MAX_PORTS - 1)], pick_start(),
                          4'($urandom_range(0, 8)), {$urandom(), $urandom()}, pick_period()));
        end else begin
          send(write_item(sb.own_ch, 11'($urandom_range(0, 2047)), pick_start(),
                          4'($urandom_range(0, 8)), {$urandom(), $urandom()}, pick_period()));
        end
        if ($urandom_range(0, 49) == 0) drain();
      end
    end
    drain();

    $display("run covered %0d writes and %0d ticks across %0d bus settings",
             sb.writes_seen, sb.ticks_seen, cfg_writes);
    $display("%0d frames checked, %0d mismatches", sb.frames_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
